### rtl/sbfd_pkg.sv
// Package: shared constants, types and codes for the shared buffer frame dispatcher.
package sbfd_pkg;

	localparam int MAX_PROC    = 8;
	localparam int QUEUE_DEPTH = 256;
	localparam int TAG_BITS    = 8;

	localparam int LEN_W      = 14;
	localparam int LEVEL_W    = 20;
	localparam int QUANTA_W   = 16;
	localparam int NPROC_W    = 4;
	localparam int PROC_W     = 3;
	localparam int CNT_W      = 32;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int OUTCOME_W  = 3;

	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W  = TAG_BITS + LEN_W;
	localparam int ACTIVE_W = $clog2(MAX_PROC + 1);

	// Input word kinds
	typedef enum logic {
		KIND_ARRIVAL    = 1'b0,
		KIND_COMPLETION = 1'b1
	} kind_t;

	// Result outcome codes
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_DROPPED = 3'd0,
		OUT_STARTED = 3'd1,
		OUT_QUEUED  = 3'd2,
		OUT_DONE    = 3'd3,
		OUT_IGNORED = 3'd4
	} outcome_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY  = 2'd0,
		REG_WATERMARK = 2'd1,
		REG_QUANTA    = 2'd2,
		REG_NPROC     = 2'd3
	} cfg_reg_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic read;
		logic exec;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

### rtl/sbfd_if.sv
// Interfaces: input event channel and result channel.
interface sbfd_event_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic [sbfd_pkg::TAG_BITS-1:0]     frame_tag;
	logic [sbfd_pkg::LEN_W-1:0]        frame_length;
	logic [sbfd_pkg::PROC_W-1:0]       done_processor;

	modport source (output valid, kind, frame_tag, frame_length, done_processor, input ready);
	modport sink   (input valid, kind, frame_tag, frame_length, done_processor, output ready);
endinterface

interface sbfd_result_if;
	logic                              valid;
	logic                              ready;
	logic [sbfd_pkg::OUTCOME_W-1:0]    outcome;
	logic                              pause_request;
	logic                              start_valid;
	logic [sbfd_pkg::PROC_W-1:0]       start_processor;
	logic [sbfd_pkg::TAG_BITS-1:0]     start_tag;
	logic [sbfd_pkg::TAG_BITS-1:0]     released_tag;
	logic [sbfd_pkg::LEVEL_W-1:0]      buffer_level;
	logic [sbfd_pkg::CNT_W-1:0]        dropped_total;
	logic [sbfd_pkg::CNT_W-1:0]        processed_total;

	modport source (output valid, outcome, pause_request, start_valid, start_processor,
		start_tag, released_tag, buffer_level, dropped_total, processed_total, input ready);
	modport sink   (input valid, outcome, pause_request, start_valid, start_processor,
		start_tag, released_tag, buffer_level, dropped_total, processed_total, output ready);
endinterface

### rtl/sbfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sbfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/sbfd_ctrl.sv
// Controller: sequences accept, queue head read and execute for each word.
module sbfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbfd_pkg::status_t status,
	output sbfd_pkg::cmd_t    cmd
);

	sbfd_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbfd_pkg::ST_IDLE: begin
				if (in_valid) state_d = sbfd_pkg::ST_READ;
			end
			sbfd_pkg::ST_READ: begin
				state_d = sbfd_pkg::ST_EXEC;
			end
			sbfd_pkg::ST_EXEC: begin
				if (status.out_free) state_d = sbfd_pkg::ST_IDLE;
			end
			default: state_d = sbfd_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			sbfd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sbfd_pkg::ST_READ: begin
				cmd.read = 1'b1;
			end
			sbfd_pkg::ST_EXEC: begin
				cmd.exec = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Checks
	a_read_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbfd_pkg::ST_READ |=> state_q == sbfd_pkg::ST_EXEC)
		else $error("read cycle not followed by execute");
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == sbfd_pkg::ST_IDLE && !cmd.exec)
		else $error("word loaded outside idle");
	a_exec_one_shot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !cmd.exec && !cmd.read)
		else $error("execute repeated for one word");

endmodule

### rtl/sbfd_dp.sv
// Datapath: config registers, buffer accounting, processor table, wait queue, result register.
module sbfd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [sbfd_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [sbfd_pkg::CFG_DATA_W-1:0]     wr_data,
	input  sbfd_pkg::cmd_t                      cmd,
	output sbfd_pkg::status_t                   status,
	input  logic                                in_kind,
	input  logic [sbfd_pkg::TAG_BITS-1:0]       in_tag,
	input  logic [sbfd_pkg::LEN_W-1:0]          in_len,
	input  logic [sbfd_pkg::PROC_W-1:0]         in_proc,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sbfd_pkg::OUTCOME_W-1:0]      out_outcome,
	output logic                                out_pause,
	output logic                                out_start_valid,
	output logic [sbfd_pkg::PROC_W-1:0]         out_start_proc,
	output logic [sbfd_pkg::TAG_BITS-1:0]       out_start_tag,
	output logic [sbfd_pkg::TAG_BITS-1:0]       out_released_tag,
	output logic [sbfd_pkg::LEVEL_W-1:0]        out_level,
	output logic [sbfd_pkg::CNT_W-1:0]          out_dropped,
	output logic [sbfd_pkg::CNT_W-1:0]          out_processed
);

	localparam int MP = sbfd_pkg::MAX_PROC;
	localparam int TW = sbfd_pkg::TAG_BITS;
	localparam int LW = sbfd_pkg::LEN_W;
	localparam int VW = sbfd_pkg::LEVEL_W;
	localparam int PW = sbfd_pkg::PROC_W;
	localparam int QW = sbfd_pkg::QPTR_W;
	localparam int CW = sbfd_pkg::QCNT_W;
	localparam int AW = sbfd_pkg::ACTIVE_W;
	localparam int EW = sbfd_pkg::ENTRY_W;

	// Configuration registers
	logic [VW-1:0]                   capacity_q, watermark_q;
	logic [sbfd_pkg::QUANTA_W-1:0]   quanta_q;
	logic [sbfd_pkg::NPROC_W-1:0]    nproc_q;

	// Latched input word
	logic          kind_q;
	logic [TW-1:0] tag_q;
	logic [LW-1:0] len_q;
	logic [PW-1:0] proc_q;

	// Block state
	logic [VW-1:0]           level_q;
	logic [MP-1:0]           busy_q;
	logic [TW-1:0]           ptag_q [MP];
	logic [LW-1:0]           plen_q [MP];
	logic [QW-1:0]           head_q, tail_q;
	logic [CW-1:0]           count_q;
	logic [sbfd_pkg::CNT_W-1:0] drop_q, done_q;
	logic                    out_valid_q;

	// Queue memory
	logic          q_we;
	logic [EW-1:0] q_rdata;

	// Step results
	logic [AW-1:0] active;
	logic          idle_found;
	logic [PW-1:0] idle_idx;
	logic [VW:0]   sum;
	logic          admit, q_full, proc_valid, proc_active, pop;
	logic [VW-1:0] new_level;
	logic [VW-1:0] rel_len;
	logic [sbfd_pkg::OUTCOME_W-1:0] outcome;
	logic          pause, start_v, do_drop, do_done, do_start_arr;
	logic [PW-1:0] start_p;
	logic [TW-1:0] start_t, rel_t;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= VW'(65536);
			watermark_q <= '0;
			quanta_q    <= '0;
			nproc_q     <= sbfd_pkg::NPROC_W'(1);
		end else if (wr_en) begin
			case (sbfd_pkg::cfg_reg_t'(wr_index))
				sbfd_pkg::REG_CAPACITY:  capacity_q  <= wr_data[VW-1:0];
				sbfd_pkg::REG_WATERMARK: watermark_q <= wr_data[VW-1:0];
				sbfd_pkg::REG_QUANTA:    quanta_q    <= wr_data[sbfd_pkg::QUANTA_W-1:0];
				sbfd_pkg::REG_NPROC:     nproc_q     <= wr_data[sbfd_pkg::NPROC_W-1:0];
				default: ;
			endcase
		end
	end

	// Input word capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			tag_q  <= in_tag;
			len_q  <= in_len;
			proc_q <= in_proc;
		end
	end

	sbfd_ram #(
		.WIDTH(EW),
		.DEPTH(sbfd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (q_we),
		.waddr(tail_q),
		.wdata({len_q, tag_q}),
		.re   (cmd.read),
		.raddr(head_q),
		.rdata(q_rdata)
	);

	// Processor count clamp and lowest idle processor search
	always_comb begin
		active = (32'(nproc_q) > MP) ? AW'(MP) : AW'(nproc_q);
		idle_found = 1'b0;
		idle_idx   = '0;
		for (int i = MP - 1; i >= 0; i--) begin
			if (32'(i) < 32'(active) && !busy_q[i]) begin
				idle_found = 1'b1;
				idle_idx   = PW'(i);
			end
		end
	end

	// Step decision
	always_comb begin
		sum         = {1'b0, level_q} + (VW + 1)'(len_q);
		admit       = sum < {1'b0, capacity_q};
		q_full      = 32'(count_q) >= sbfd_pkg::QUEUE_DEPTH;
		proc_valid  = 32'(proc_q) < MP && busy_q[proc_q];
		proc_active = 32'(proc_q) < 32'(active);
		rel_len     = VW'(plen_q[proc_q]);
		pop         = 1'b0;
		q_we        = 1'b0;
		new_level   = level_q;
		outcome     = sbfd_pkg::OUT_DROPPED;
		pause       = 1'b0;
		start_v     = 1'b0;
		start_p     = '0;
		start_t     = '0;
		rel_t       = '0;
		do_drop     = 1'b0;
		do_done     = 1'b0;
		do_start_arr = 1'b0;
		if (sbfd_pkg::kind_t'(kind_q) == sbfd_pkg::KIND_ARRIVAL) begin
			if (!admit || (!idle_found && q_full)) begin
				do_drop = 1'b1;
			end else begin
				new_level = sum[VW-1:0];
				pause = quanta_q != '0 && watermark_q != '0 && sum[VW-1:0] >= watermark_q;
				if (idle_found) begin
					do_start_arr = 1'b1;
					outcome = sbfd_pkg::OUT_STARTED;
					start_v = 1'b1;
					start_p = idle_idx;
					start_t = tag_q;
				end else begin
					q_we = cmd.exec;
					outcome = sbfd_pkg::OUT_QUEUED;
				end
			end
		end else begin
			if (proc_valid) begin
				rel_t     = ptag_q[proc_q];
				new_level = (level_q >= rel_len) ? level_q - rel_len : '0;
				do_done   = 1'b1;
				outcome   = sbfd_pkg::OUT_DONE;
				if (count_q != '0 && proc_active) begin
					pop     = 1'b1;
					start_v = 1'b1;
					start_p = proc_q;
					start_t = q_rdata[TW-1:0];
				end
			end else begin
				outcome = sbfd_pkg::OUT_IGNORED;
			end
		end
	end

	// Block state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			busy_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			drop_q  <= '0;
			done_q  <= '0;
		end else if (cmd.exec) begin
			level_q <= new_level;
			if (do_drop) drop_q <= drop_q + 1'b1;
			if (do_done) begin
				done_q <= done_q + 1'b1;
				busy_q[proc_q] <= pop;
			end
			if (do_start_arr) busy_q[idle_idx] <= 1'b1;
			if (q_we) begin
				tail_q  <= (32'(tail_q) == sbfd_pkg::QUEUE_DEPTH - 1) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (pop) begin
				head_q  <= (32'(head_q) == sbfd_pkg::QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Processor table payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (do_start_arr) begin
				ptag_q[idle_idx] <= tag_q;
				plen_q[idle_idx] <= len_q;
			end
			if (pop) begin
				ptag_q[proc_q] <= q_rdata[TW-1:0];
				plen_q[proc_q] <= q_rdata[EW-1:TW];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_outcome      <= outcome;
			out_pause        <= pause;
			out_start_valid  <= start_v;
			out_start_proc   <= start_p;
			out_start_tag    <= start_t;
			out_released_tag <= rel_t;
			out_level        <= new_level;
			out_dropped      <= do_drop ? drop_q + 1'b1 : drop_q;
			out_processed    <= do_done ? done_q + 1'b1 : done_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= sbfd_pkg::QUEUE_DEPTH)
		else $error("queue count above depth");
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) % sbfd_pkg::QUEUE_DEPTH ==
		(32'(tail_q) + sbfd_pkg::QUEUE_DEPTH - 32'(head_q)) % sbfd_pkg::QUEUE_DEPTH)
		else $error("queue pointers disagree with count");
	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !out_valid_q || out_ready)
		else $error("result register overwritten");
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(q_we && pop))
		else $error("queue push and pop on one word");

endmodule

### rtl/shared_buffer_frame_dispatcher.sv
// Top level: shared buffer frame dispatcher.
// Usage:
//   events  - input channel (valid/ready). Each word is either a frame arrival
//             (kind 0: frame_tag, frame_length) or a processor completion
//             (kind 1: done_processor).
//   results - output channel (valid/ready), one result word per input word:
//             outcome, pause request, processor start, released tag, buffer
//             level and the wrapping drop and completion totals.
//   wr_en/wr_index/wr_data - register writes: 0 buffer capacity, 1 high
//             watermark, 2 pause quanta, 3 processors in use. Write only idle.
// Sequence: an accepted word is latched, then the wait queue RAM head entry is
// read into a register, then the execute step writes the result register. One
// word is in flight at a time; the next word is accepted once execute is done.
// Reset (arst_n low): buffer empty, all processors idle, wait queue empty,
// totals zero, registers at their defaults; no clearing pass is needed.
// Receiver stall: the result register holds its word; a new input word is
// still accepted and waits in the execute step until the register frees.
module shared_buffer_frame_dispatcher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [sbfd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sbfd_pkg::CFG_DATA_W-1:0] wr_data,
	sbfd_event_if.sink                      events,
	sbfd_result_if.source                   results
);

	sbfd_pkg::cmd_t    cmd;
	sbfd_pkg::status_t status;

	sbfd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(events.valid),
		.in_ready(events.ready),
		.status  (status),
		.cmd     (cmd)
	);

	sbfd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.cmd             (cmd),
		.status          (status),
		.in_kind         (events.kind),
		.in_tag          (events.frame_tag),
		.in_len          (events.frame_length),
		.in_proc         (events.done_processor),
		.out_valid       (results.valid),
		.out_ready       (results.ready),
		.out_outcome     (results.outcome),
		.out_pause       (results.pause_request),
		.out_start_valid (results.start_valid),
		.out_start_proc  (results.start_processor),
		.out_start_tag   (results.start_tag),
		.out_released_tag(results.released_tag),
		.out_level       (results.buffer_level),
		.out_dropped     (results.dropped_total),
		.out_processed   (results.processed_total)
	);

endmodule

### sim/tb_top.sv
// Self-checking testbench for the shared buffer frame dispatcher: random traffic, in-order check.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sbfd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 14;

	// One input word and one result word, at the widths of the ports
	typedef struct packed {
		kind_t                kind;
		logic [TAG_BITS-1:0]  tag;
		logic [LEN_W-1:0]     len;
		logic [PROC_W-1:0]    proc;
	} event_word_t;

	typedef struct packed {
		outcome_t             outcome;
		logic                 pause;
		logic                 start_valid;
		logic [PROC_W-1:0]    start_proc;
		logic [TAG_BITS-1:0]  start_tag;
		logic [TAG_BITS-1:0]  released_tag;
		logic [LEVEL_W-1:0]   level;
		logic [CNT_W-1:0]     drops;
		logic [CNT_W-1:0]     dones;
	} result_word_t;

	typedef struct packed {
		logic [TAG_BITS-1:0]  tag;
		logic [LEN_W-1:0]     len;
	} waiting_frame_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	sbfd_event_if  ev ();
	sbfd_result_if res ();

	shared_buffer_frame_dispatcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.events   (ev),
		.results  (res)
	);

	always #1 clk = ~clk;

	// Dispatcher shadow: registers and state as the block should hold them
	logic [LEVEL_W-1:0]   cfg_capacity = LEVEL_W'(65536);
	logic [LEVEL_W-1:0]   cfg_watermark = '0;
	logic [QUANTA_W-1:0]  cfg_quanta = '0;
	logic [NPROC_W-1:0]   cfg_lanes = NPROC_W'(1);
	logic [LEVEL_W-1:0]   bytes_held = '0;
	logic                 lane_busy [MAX_PROC] = '{default: 1'b0};
	logic [TAG_BITS-1:0]  lane_tag [MAX_PROC];
	logic [LEN_W-1:0]     lane_len [MAX_PROC];
	waiting_frame_t       backlog [$];
	logic [CNT_W-1:0]     drop_count = '0;
	logic [CNT_W-1:0]     done_count = '0;

	event_word_t   pending_words [$];
	result_word_t  expected_results [$];

	int items_issued = 0;
	int words_sent = 0;
	int fails = 0;
	int quiet = 0;
	int send_wait = 0;
	int stall_left = 0;
	bit tx_calm = 0;
	bit rx_calm = 0;
	logic ev_taken = 1'b0;
	logic res_taken = 1'b0;
	int outcome_tally [5] = '{default: 0};
	int pause_tally = 0;
	int deepest_backlog = 0;

	// Work out the result of one accepted word and advance the shadow state
	task automatic dispatch_word(input event_word_t w, output result_word_t r);
		int unsigned lanes;
		int unsigned idle;
		waiting_frame_t head;
		r = '0;
		r.outcome = OUT_DROPPED;
		lanes = (cfg_lanes > MAX_PROC) ? MAX_PROC : cfg_lanes;
		if (w.kind == KIND_ARRIVAL) begin
			if (int'(bytes_held) + int'(w.len) < int'(cfg_capacity)) begin
				idle = lanes;
				for (int i = MAX_PROC - 1; i >= 0; i--)
					if (i < lanes && !lane_busy[i]) idle = i;
				if (idle == lanes && backlog.size() >= QUEUE_DEPTH) begin
					drop_count++;
				end else begin
					bytes_held = bytes_held + w.len;
					r.pause = (cfg_quanta != 0) && (cfg_watermark != 0) &&
						(bytes_held >= cfg_watermark);
					if (idle < lanes) begin
						lane_busy[idle] = 1'b1;
						lane_tag[idle] = w.tag;
						lane_len[idle] = w.len;
						r.outcome = OUT_STARTED;
						r.start_valid = 1'b1;
						r.start_proc = PROC_W'(idle);
						r.start_tag = w.tag;
					end else begin
						backlog.push_back('{tag: w.tag, len: w.len});
						if (backlog.size() > deepest_backlog) deepest_backlog = backlog.size();
						r.outcome = OUT_QUEUED;
					end
				end
			end else begin
				drop_count++;
			end
		end else if (lane_busy[w.proc]) begin
			r.released_tag = lane_tag[w.proc];
			bytes_held = (bytes_held >= lane_len[w.proc]) ? bytes_held - lane_len[w.proc] : '0;
			done_count++;
			r.outcome = OUT_DONE;
			lane_busy[w.proc] = 1'b0;
			// queue head moves onto the freed processor only if it is still in use
			if (backlog.size() != 0 && w.proc < lanes) begin
				head = backlog.pop_front();
				lane_busy[w.proc] = 1'b1;
				lane_tag[w.proc] = head.tag;
				lane_len[w.proc] = head.len;
				r.start_valid = 1'b1;
				r.start_proc = w.proc;
				r.start_tag = head.tag;
			end
		end else begin
			r.outcome = OUT_IGNORED;
		end
		r.level = bytes_held;
		r.drops = drop_count;
		r.dones = done_count;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// Register write at one rising edge; the shadow takes the same masked value
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CAPACITY:  cfg_capacity = val;
			REG_WATERMARK: cfg_watermark = val;
			REG_QUANTA:    cfg_quanta = val[QUANTA_W-1:0];
			REG_NPROC:     cfg_lanes = val[NPROC_W-1:0];
			default: ;
		endcase
	endtask

	// Upper bits of the narrow registers carry junk the block must ignore
	task automatic configure(input logic [LEVEL_W-1:0] cap, input logic [LEVEL_W-1:0] wm,
			input logic [QUANTA_W-1:0] q, input logic [NPROC_W-1:0] np);
		write_reg(REG_CAPACITY, cap);
		write_reg(REG_WATERMARK, wm);
		write_reg(REG_QUANTA, {4'($urandom), q});
		write_reg(REG_NPROC, {16'($urandom), np});
	endtask

	task automatic post_word(input kind_t k, input int tag, input int len, input int proc);
		pending_words.push_back('{kind: k, tag: TAG_BITS'(tag), len: LEN_W'(len),
			proc: PROC_W'(proc)});
		items_issued++;
	endtask

	// Random traffic: arrivals, plus completions aimed mostly at processors in use
	task automatic post_random(input int count, input int arrive_pct, input int len_max,
			input int span);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99, 0) < arrive_pct)
				post_word(KIND_ARRIVAL, $urandom_range(255, 0), $urandom_range(len_max, 0),
					$urandom_range(7, 0));
			else if (span == 0 || $urandom_range(7, 0) == 0)
				post_word(KIND_COMPLETION, $urandom_range(255, 0), $urandom_range(16383, 0),
					$urandom_range(7, 0));
			else
				post_word(KIND_COMPLETION, $urandom_range(255, 0), $urandom_range(16383, 0),
					$urandom_range(span - 1, 0));
		end
	endtask

	// Block is idle once every word sent has produced its result
	task automatic wait_idle();
		do @(negedge clk);
		while (!(words_sent == items_issued && expected_results.size() == 0));
	endtask

	// Sender: new word or gap at the falling edge
	always @(negedge clk) begin
		event_word_t w;
		if (arst_n && (!ev.valid || ev_taken)) begin
			if (send_wait != 0) begin
				send_wait = send_wait - 1;
				ev.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				ev.valid <= 1'b1;
				ev.kind <= w.kind;
				ev.frame_tag <= w.tag;
				ev.frame_length <= w.len;
				ev.done_processor <= w.proc;
				send_wait = tx_calm ? 0 : $urandom_range(15, 0);
				if ($urandom_range(63, 0) == 0) tx_calm = !tx_calm;
			end else begin
				ev.valid <= 1'b0;
			end
		end
	end

	// Receiver: stall draw per result word
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				stall_left = rx_calm ? 0 : $urandom_range(15, 0);
				if ($urandom_range(63, 0) == 0) rx_calm = !rx_calm;
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Predict on accepted input words, check accepted result words
	always @(posedge clk) begin
		event_word_t  w;
		result_word_t want;
		ev_taken <= ev.valid && ev.ready;
		res_taken <= res.valid && res.ready;
		if (ev.valid && ev.ready) begin
			w = '{kind: kind_t'(ev.kind), tag: ev.frame_tag, len: ev.frame_length,
				proc: ev.done_processor};
			dispatch_word(w, want);
			expected_results.push_back(want);
			words_sent++;
		end
		if (res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				$error("result word with no expectation pending");
				fails++;
			end else begin
				want = expected_results.pop_front();
				outcome_tally[want.outcome]++;
				if (want.pause) pause_tally++;
				check_field("outcome", want.outcome, res.outcome);
				check_field("pause_request", want.pause, res.pause_request);
				check_field("start_valid", want.start_valid, res.start_valid);
				check_field("start_processor", want.start_proc, res.start_processor);
				check_field("start_tag", want.start_tag, res.start_tag);
				check_field("released_tag", want.released_tag, res.released_tag);
				check_field("buffer_level", want.level, res.buffer_level);
				check_field("dropped_total", want.drops, res.dropped_total);
				check_field("processed_total", want.dones, res.processed_total);
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((ev.valid && ev.ready) || (res.valid && res.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned cap, wm, q, np, pct, lmax, n, span;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_CAPACITY;
		wr_data = '0;
		ev.valid = 1'b0;
		ev.kind = KIND_ARRIVAL;
		ev.frame_tag = '0;
		ev.frame_length = '0;
		ev.done_processor = '0;
		res.ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: one processor, 64 KiB buffer; fill to the byte below capacity
		post_word(KIND_COMPLETION, 0, 0, 0);
		post_word(KIND_ARRIVAL, 8'h00, 0, 0);
		post_word(KIND_ARRIVAL, 8'hFF, 16383, 7);
		post_word(KIND_ARRIVAL, 8'hA5, 16383, 0);
		post_word(KIND_ARRIVAL, 8'h5A, 16383, 0);
		post_word(KIND_ARRIVAL, 8'h3C, 16383, 0);
		post_word(KIND_ARRIVAL, 8'hC3, 4, 0);
		post_word(KIND_ARRIVAL, 8'h81, 3, 0);
		post_word(KIND_COMPLETION, 0, 0, 7);
		post_word(KIND_COMPLETION, 0, 0, 0);
		post_word(KIND_COMPLETION, 0, 0, 0);
		wait_idle();

		// Processor count above the maximum, pause at the lowest watermark
		configure(20'hFFFFF, 20'd1, 16'hFFFF, 4'd15);
		post_word(KIND_ARRIVAL, 8'h11, 14'h2AAA, 0);
		for (int i = 0; i < 6; i++)
			post_word(KIND_ARRIVAL, 8'h12 + i, 14'h1555, 0);
		post_word(KIND_ARRIVAL, 8'h18, 14'h1555, 0);
		wait_idle();

		// Fewer processors than are busy: completion above the count does not pull the queue
		configure(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 4'd2);
		post_word(KIND_COMPLETION, 0, 0, 5);
		post_word(KIND_COMPLETION, 0, 0, 1);
		post_word(KIND_COMPLETION, 0, 0, 5);
		wait_idle();

		// Zero capacity drops even a zero-length frame
		configure(20'd0, 20'd0, 16'd0, 4'd8);
		post_word(KIND_ARRIVAL, 8'h77, 0, 0);
		wait_idle();

		// Random phases, the first few at fixed corner settings
		for (int ph = 0; ph < PHASES; ph++) begin
			n = 110;
			pct = $urandom_range(70, 30);
			case ($urandom_range(2, 0))
				0: lmax = 63;
				1: lmax = 2047;
				default: lmax = 16383;
			endcase
			case (ph)
				0: begin
					// no processors: every admitted frame queues until the queue is full
					cap = 20'hFFFFF; wm = 5000; q = 100; np = 0;
					n = 300; pct = 100; lmax = 63;
				end
				1: begin
					cap = 20'hFFFFF; wm = 0; q = 65535; np = 8; pct = 10; lmax = 63;
					n = 150;
				end
				2: begin
					cap = 0; wm = 1; q = 1; np = 4;
				end
				3: begin
					cap = 65536; wm = 20'hFFFFF; q = 65535; np = 9;
				end
				4: begin
					cap = 40000; wm = 20000; q = 1; np = 3; lmax = 16383;
				end
				5: begin
					cap = 20'hFFFFF; wm = 30000; q = 500; np = 2; pct = 30;
				end
				default: begin
					cap = ($urandom_range(3, 0) == 0) ? $urandom_range(20'hFFFFF, 0)
						: $urandom_range(20'hFFFFF, 20000);
					wm = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(cap, 0);
					q = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(65535, 1);
					np = $urandom_range(15, 0);
				end
			endcase
			span = (ph == 5) ? MAX_PROC : ((np > MAX_PROC) ? MAX_PROC : np);
			configure(LEVEL_W'(cap), LEVEL_W'(wm), QUANTA_W'(q), NPROC_W'(np));
			post_random(n, pct, lmax, span);
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected result words never arrived", expected_results.size());
			fails++;
		end
		$display("Covered %0d words: %0d started, %0d queued, %0d dropped, %0d done, %0d ignored",
			words_sent, outcome_tally[OUT_STARTED], outcome_tally[OUT_QUEUED],
			outcome_tally[OUT_DROPPED], outcome_tally[OUT_DONE], outcome_tally[OUT_IGNORED]);
		$display("Pause requests %0d, deepest wait queue %0d, mismatches %0d",
			pause_tally, deepest_backlog, fails);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/sbfd_pkg.sv
rtl/sbfd_if.sv
rtl/sbfd_ram.sv
rtl/sbfd_ctrl.sv
rtl/sbfd_dp.sv
rtl/shared_buffer_frame_dispatcher.sv
sim/tb_top.sv
